// ===== rtl/psch_pkg.sv =====
// Package for the process scheduler: payload structs, opcodes, status codes,
// controller states and the command/status bundle between control and datapath.
// No dependencies.
package psch_pkg;

   // Payload of one request beat
   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  new_priority;
      logic [7:0]  arrival_offset;
      logic [7:0]  service_time;
      logic [15:0] target_id;
   } req_type;

   // Payload of one response beat
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] assigned_id;
      logic [15:0] running_id;
      logic [15:0] finished_id;
      logic [31:0] finish_time;
      logic [31:0] system_time;
      logic        all_done;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_TICK     = 3'd1,
      OP_EXPIRE   = 3'd2,
      OP_BLOCK    = 3'd3,
      OP_UNBLOCK  = 3'd4,
      OP_SUSPEND  = 3'd5,
      OP_RESUME   = 3'd6,
      OP_NOP      = 3'd7
   } op_type;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_TABLE_FULL  = 3'd1;
   localparam logic [2:0] ST_NO_RUNNING  = 3'd2;
   localparam logic [2:0] ST_QUEUE_EMPTY = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
   localparam logic [2:0] ST_WAITING     = 3'd5;
   localparam logic [2:0] ST_ALL_DONE    = 3'd6;

   localparam logic [1:0] MODE_FCFS = 2'd0;
   localparam logic [1:0] MODE_PRIO = 2'd1;
   localparam logic [1:0] MODE_RR   = 2'd2;
   localparam logic [1:0] MODE_ALT  = 2'd3;  // decoded as FCFS

   localparam logic CSR_SCHED_MODE   = 1'b0;
   localparam logic CSR_SLICE_LENGTH = 1'b1;

   localparam logic [1:0] RST_MODE  = MODE_FCFS;
   localparam logic [7:0] RST_SLICE = 8'd4;

   // Datapath micro-operations
   typedef enum logic [4:0] {
      U_NONE,
      U_LATCH,
      U_SORT_LOAD,
      U_SORT_STEP,
      U_SORT_END,
      U_SCAN,
      U_FULL,
      U_ADD,
      U_WAIT,
      U_ALLDONE,
      U_NORUN,
      U_EMPTY,
      U_TICK,
      U_MOD,
      U_PUSH_RUN,
      U_HEAD_LOAD,
      U_SHIFT,
      U_POP_END,
      U_TAIL_SET,
      U_EXP_TAIL,
      U_PARK,
      U_REL,
      U_REL_END,
      U_RESP
   } uop_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_PREP,
      CS_SORT_LOAD,
      CS_SORT_STEP,
      CS_DECODE,
      CS_SCAN,
      CS_TICK,
      CS_MOD,
      CS_MOD_CHECK,
      CS_START,
      CS_HEAD_SHIFT,
      CS_EXP_TAIL,
      CS_EXP_PUSH,
      CS_REL,
      CS_RESP
   } ctrl_state_type;

   typedef struct packed {
      uop_type uop;
   } dp_cmd_type;

   typedef struct packed {
      op_type opcode;
      logic   run_valid;
      logic   rcnt_zero;
      logic   rcnt_multi;
      logic   waiters;
      logic   mode_rr;
      logic   mode_fcfs;
      logic   tgt_empty;
      logic   idx_end;
      logic   rel_end;
      logic   scan_free;
      logic   scan_last;
      logic   swapped;
      logic   tick_last;
      logic   mod_last;
      logic   slice_hit;
      logic   rsp_room;
   } dp_status_type;

endpackage

// ===== rtl/psch_ctrl.sv =====
// Scheduler controller: sequences sort passes, slot scan, tick, slice check,
// queue shifts and id release over the datapath. Depends on psch_pkg.
module psch_ctrl import psch_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type stat,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and micro-op
   always_comb begin
      state_in  = state_ff;
      cmd.uop   = U_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.uop  = U_LATCH;
               state_in = CS_PREP;
            end
         end
         CS_PREP: begin
            state_in = (!stat.mode_rr && stat.rcnt_multi) ? CS_SORT_LOAD : CS_DECODE;
         end
         CS_SORT_LOAD: begin
            cmd.uop  = U_SORT_LOAD;
            state_in = CS_SORT_STEP;
         end
         CS_SORT_STEP: begin
            if (!stat.idx_end) begin
               cmd.uop = U_SORT_STEP;
            end else begin
               cmd.uop  = U_SORT_END;
               state_in = stat.swapped ? CS_SORT_LOAD : CS_DECODE;
            end
         end
         CS_DECODE: begin
            state_in = CS_RESP;
            case (stat.opcode)
               OP_ADD: state_in = CS_SCAN;
               OP_TICK: begin
                  if (stat.run_valid) begin
                     state_in = CS_TICK;
                  end else if (!stat.rcnt_zero) begin
                     state_in = CS_START;
                  end else if (stat.waiters) begin
                     cmd.uop = U_WAIT;
                  end else begin
                     cmd.uop = U_ALLDONE;
                  end
               end
               OP_EXPIRE: begin
                  if (!stat.run_valid) begin
                     cmd.uop = U_NORUN;
                  end else if (stat.mode_fcfs && !stat.rcnt_zero) begin
                     cmd.uop  = U_TAIL_SET;
                     state_in = CS_EXP_TAIL;
                  end else begin
                     state_in = CS_EXP_PUSH;
                  end
               end
               OP_BLOCK, OP_SUSPEND: begin
                  cmd.uop = stat.run_valid ? U_PARK : U_NORUN;
               end
               OP_UNBLOCK, OP_RESUME: begin
                  if (stat.tgt_empty) begin
                     cmd.uop = U_EMPTY;
                  end else begin
                     state_in = CS_REL;
                  end
               end
               default: state_in = CS_RESP;
            endcase
         end
         CS_SCAN: begin
            if (stat.scan_free) begin
               cmd.uop  = U_ADD;
               state_in = CS_RESP;
            end else if (stat.scan_last) begin
               cmd.uop  = U_FULL;
               state_in = CS_RESP;
            end else begin
               cmd.uop = U_SCAN;
            end
         end
         CS_TICK: begin
            cmd.uop  = U_TICK;
            state_in = (stat.tick_last || !stat.mode_rr) ? CS_START : CS_MOD;
         end
         CS_MOD: begin
            cmd.uop = U_MOD;
            if (stat.mod_last) state_in = CS_MOD_CHECK;
         end
         CS_MOD_CHECK: begin
            if (stat.slice_hit) cmd.uop = U_PUSH_RUN;
            state_in = CS_START;
         end
         CS_START: begin
            if (!stat.run_valid && !stat.rcnt_zero) begin
               cmd.uop  = U_HEAD_LOAD;
               state_in = CS_HEAD_SHIFT;
            end else begin
               state_in = CS_RESP;
            end
         end
         CS_HEAD_SHIFT: begin
            if (!stat.idx_end) begin
               cmd.uop = U_SHIFT;
            end else begin
               cmd.uop  = U_POP_END;
               state_in = CS_RESP;
            end
         end
         CS_EXP_TAIL: begin
            cmd.uop  = U_EXP_TAIL;
            state_in = CS_EXP_PUSH;
         end
         CS_EXP_PUSH: begin
            cmd.uop  = U_PUSH_RUN;
            state_in = CS_RESP;
         end
         CS_REL: begin
            if (!stat.rel_end) begin
               cmd.uop = U_REL;
            end else begin
               cmd.uop  = U_REL_END;
               state_in = CS_RESP;
            end
         end
         CS_RESP: begin
            if (stat.rsp_room) begin
               cmd.uop  = U_RESP;
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

endmodule

// ===== rtl/psch_datapath.sv =====
// Scheduler datapath: process table, ready/blocked/suspended queues, running
// slot, clocks, config registers and response register. Depends on psch_pkg.
module psch_datapath import psch_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type stat,
   input  req_type       req_data,
   output rsp_type       rsp_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic          csr_index,
   input  logic [7:0]    csr_data
);

   localparam int SW = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;
   localparam int CW = $clog2(MAX_PROCS + 1);
   localparam logic [CW-1:0] LAST_IDX = CW'(MAX_PROCS - 1);

   // Process table (no reset, read only for occupied slots)
   logic [15:0] id_mem   [MAX_PROCS];
   logic [3:0]  prio_mem [MAX_PROCS];
   logic [31:0] arr_mem  [MAX_PROCS];
   logic [7:0]  rem_mem  [MAX_PROCS];
   logic [7:0]  used_mem [MAX_PROCS];
   logic [SW-1:0] rdy_q  [MAX_PROCS];
   logic [SW-1:0] blk_q  [MAX_PROCS];
   logic [SW-1:0] sus_q  [MAX_PROCS];

   // Control state
   logic [MAX_PROCS-1:0] occ_ff;
   logic [CW-1:0] rcnt_ff, bcnt_ff, scnt_ff;
   logic          run_valid_ff;
   logic [SW-1:0] run_slot_ff;
   logic [15:0]   next_id_ff;
   logic [31:0]   clk_ff;
   logic          done_ff;
   logic [1:0]    mode_ff;
   logic [7:0]    slice_ff;
   logic          rsp_valid_ff;

   // Work registers
   req_type       req_ff;
   logic [CW-1:0] idx_ff, k_ff;
   logic [SW-1:0] cur_slot_ff;
   logic [31:0]   cur_key_ff;
   logic          swapped_ff, found_ff, used_nz_ff;
   logic [7:0]    mod_rem_ff, mod_val_ff;
   logic [2:0]    mod_cnt_ff;
   logic [2:0]    status_ff;
   logic [15:0]   assigned_ff, fin_id_ff;
   logic [31:0]   fin_time_ff;
   rsp_type       rsp_ff;

   logic [SW-1:0] ix, ix_m1, rq_rd, bq_rd, sq_rd, relq_rd, tbl_addr;
   logic [SW-1:0] rcnt_ix, k_ix, bcnt_ix, scnt_ix;
   logic          rel_blk, mode_prio, goes_ahead, match;
   logic [CW-1:0] rel_cnt, idx_m1_full;
   logic [15:0]   t_id;
   logic [3:0]    t_prio;
   logic [31:0]   t_arr, t_key;
   logic [7:0]    t_rem, t_used, sl, serv;
   logic [8:0]    r2;
   logic [7:0]    mod_next;

   // Read addressing
   assign ix          = idx_ff[SW-1:0];
   assign idx_m1_full = idx_ff - CW'(1);
   assign ix_m1       = idx_m1_full[SW-1:0];
   assign rcnt_ix     = rcnt_ff[SW-1:0];
   assign bcnt_ix     = bcnt_ff[SW-1:0];
   assign scnt_ix     = scnt_ff[SW-1:0];
   assign k_ix        = k_ff[SW-1:0];
   assign rq_rd       = rdy_q[ix];
   assign bq_rd       = blk_q[ix];
   assign sq_rd       = sus_q[ix];
   assign rel_blk     = (op_type'(req_ff.opcode) == OP_UNBLOCK);
   assign relq_rd     = rel_blk ? bq_rd : sq_rd;
   assign rel_cnt     = rel_blk ? bcnt_ff : scnt_ff;

   always_comb begin
      if (cmd.uop == U_TICK || cmd.uop == U_RESP) begin
         tbl_addr = run_slot_ff;
      end else if (cmd.uop == U_REL) begin
         tbl_addr = relq_rd;
      end else begin
         tbl_addr = rq_rd;
      end
   end

   assign t_id   = id_mem[tbl_addr];
   assign t_prio = prio_mem[tbl_addr];
   assign t_arr  = arr_mem[tbl_addr];
   assign t_rem  = rem_mem[tbl_addr];
   assign t_used = used_mem[tbl_addr];

   // Sort key and ordering compare
   assign mode_prio  = (mode_ff == MODE_PRIO);
   assign t_key      = mode_prio ? {28'd0, t_prio} : t_arr;
   assign goes_ahead = mode_prio ? (t_key > cur_key_ff) : (t_key < cur_key_ff);
   assign match      = (t_id == req_ff.target_id);

   // Slice remainder, one bit per step
   assign sl       = (slice_ff == 8'd0) ? 8'd1 : slice_ff;
   assign r2       = {mod_rem_ff, mod_val_ff[7]};
   assign mod_next = (r2 >= {1'b0, sl}) ? 8'(r2 - {1'b0, sl}) : r2[7:0];
   assign serv     = (req_ff.service_time == 8'd0) ? 8'd1 : req_ff.service_time;

   // Status to controller
   always_comb begin
      stat.opcode     = op_type'(req_ff.opcode);
      stat.run_valid  = run_valid_ff;
      stat.rcnt_zero  = (rcnt_ff == '0);
      stat.rcnt_multi = (rcnt_ff > CW'(1));
      stat.waiters    = (bcnt_ff != '0) || (scnt_ff != '0);
      stat.mode_rr    = (mode_ff == MODE_RR);
      stat.mode_fcfs  = (mode_ff == MODE_FCFS) || (mode_ff == MODE_ALT);
      stat.tgt_empty  = (rel_cnt == '0);
      stat.idx_end    = (idx_ff >= rcnt_ff);
      stat.rel_end    = (idx_ff >= rel_cnt);
      stat.scan_free  = !occ_ff[ix];
      stat.scan_last  = (idx_ff == LAST_IDX);
      stat.swapped    = swapped_ff;
      stat.tick_last  = (t_rem == 8'd1);
      stat.mod_last   = (mod_cnt_ff == 3'd7);
      stat.slice_hit  = used_nz_ff && (mod_rem_ff == 8'd0);
      stat.rsp_room   = !rsp_valid_ff || rsp_ready;
   end

   // Control state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rcnt_ff      <= '0;
         bcnt_ff      <= '0;
         scnt_ff      <= '0;
         run_valid_ff <= 1'b0;
         run_slot_ff  <= '0;
         next_id_ff   <= 16'd1;
         clk_ff       <= '0;
         done_ff      <= 1'b0;
         mode_ff      <= RST_MODE;
         slice_ff     <= RST_SLICE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SCHED_MODE:   mode_ff  <= csr_data[1:0];
               CSR_SLICE_LENGTH: slice_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.uop == U_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (cmd.uop)
            U_ADD: begin
               occ_ff[ix] <= 1'b1;
               rcnt_ff    <= rcnt_ff + CW'(1);
               next_id_ff <= (next_id_ff == 16'hFFFF) ? 16'd1 : next_id_ff + 16'd1;
               done_ff    <= 1'b0;
            end
            U_ALLDONE: done_ff <= 1'b1;
            U_TICK: begin
               clk_ff <= clk_ff + 32'd1;
               if (t_rem == 8'd1) begin
                  occ_ff[run_slot_ff] <= 1'b0;
                  run_valid_ff        <= 1'b0;
               end
            end
            U_PUSH_RUN: begin
               rcnt_ff      <= rcnt_ff + CW'(1);
               run_valid_ff <= 1'b0;
            end
            U_HEAD_LOAD: begin
               run_slot_ff  <= rq_rd;
               run_valid_ff <= 1'b1;
            end
            U_POP_END: rcnt_ff <= rcnt_ff - CW'(1);
            U_PARK: begin
               run_valid_ff <= 1'b0;
               if (op_type'(req_ff.opcode) == OP_BLOCK) begin
                  bcnt_ff <= bcnt_ff + CW'(1);
               end else begin
                  scnt_ff <= scnt_ff + CW'(1);
               end
            end
            U_REL: begin
               if (match) rcnt_ff <= rcnt_ff + CW'(1);
            end
            U_REL_END: begin
               if (rel_blk) begin
                  bcnt_ff <= k_ff;
               end else begin
                  scnt_ff <= k_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Table and queue storage
   always_ff @(posedge clock) begin
      unique case (cmd.uop)
         U_SORT_STEP: rdy_q[ix_m1] <= goes_ahead ? rq_rd : cur_slot_ff;
         U_SORT_END:  rdy_q[ix_m1] <= cur_slot_ff;
         U_SHIFT:     rdy_q[ix_m1] <= rq_rd;
         U_ADD: begin
            id_mem[ix]     <= next_id_ff;
            prio_mem[ix]   <= req_ff.new_priority;
            arr_mem[ix]    <= clk_ff + {24'd0, req_ff.arrival_offset};
            rem_mem[ix]    <= serv;
            used_mem[ix]   <= 8'd0;
            rdy_q[rcnt_ix] <= ix;
         end
         U_TICK: begin
            used_mem[run_slot_ff] <= t_used + 8'd1;
            rem_mem[run_slot_ff]  <= t_rem - 8'd1;
         end
         U_EXP_TAIL: arr_mem[run_slot_ff] <= t_arr + 32'd1;
         U_PUSH_RUN: rdy_q[rcnt_ix] <= run_slot_ff;
         U_PARK: begin
            if (op_type'(req_ff.opcode) == OP_BLOCK) begin
               blk_q[bcnt_ix] <= run_slot_ff;
            end else begin
               sus_q[scnt_ix] <= run_slot_ff;
            end
         end
         U_REL: begin
            if (match) begin
               rdy_q[rcnt_ix] <= relq_rd;
            end else if (rel_blk) begin
               blk_q[k_ix] <= relq_rd;
            end else begin
               sus_q[k_ix] <= relq_rd;
            end
         end
         default: ;
      endcase
   end

   // Work registers and response
   always_ff @(posedge clock) begin
      unique case (cmd.uop)
         U_LATCH: begin
            req_ff      <= req_data;
            idx_ff      <= '0;
            k_ff        <= '0;
            found_ff    <= 1'b0;
            status_ff   <= ST_OK;
            assigned_ff <= '0;
            fin_id_ff   <= '0;
            fin_time_ff <= '0;
         end
         U_SORT_LOAD: begin
            cur_slot_ff <= rq_rd;
            cur_key_ff  <= t_key;
            idx_ff      <= CW'(1);
            swapped_ff  <= 1'b0;
         end
         U_SORT_STEP: begin
            if (goes_ahead) begin
               swapped_ff <= 1'b1;
            end else begin
               cur_slot_ff <= rq_rd;
               cur_key_ff  <= t_key;
            end
            idx_ff <= idx_ff + CW'(1);
         end
         U_SORT_END: idx_ff <= '0;
         U_SCAN:     idx_ff <= idx_ff + CW'(1);
         U_FULL:     status_ff <= ST_TABLE_FULL;
         U_ADD:      assigned_ff <= next_id_ff;
         U_WAIT:     status_ff <= ST_WAITING;
         U_ALLDONE:  status_ff <= ST_ALL_DONE;
         U_NORUN:    status_ff <= ST_NO_RUNNING;
         U_EMPTY:    status_ff <= ST_QUEUE_EMPTY;
         U_TICK: begin
            if (t_rem == 8'd1) begin
               fin_id_ff   <= t_id;
               fin_time_ff <= clk_ff + 32'd1;
            end
            mod_val_ff <= t_used + 8'd1;
            used_nz_ff <= (t_used != 8'hFF);
            mod_rem_ff <= '0;
            mod_cnt_ff <= '0;
            idx_ff     <= '0;
         end
         U_MOD: begin
            mod_rem_ff <= mod_next;
            mod_val_ff <= {mod_val_ff[6:0], 1'b0};
            mod_cnt_ff <= mod_cnt_ff + 3'd1;
         end
         U_HEAD_LOAD: idx_ff <= CW'(1);
         U_SHIFT:     idx_ff <= idx_ff + CW'(1);
         U_TAIL_SET:  idx_ff <= rcnt_ff - CW'(1);
         U_REL: begin
            if (match) begin
               found_ff <= 1'b1;
            end else begin
               k_ff <= k_ff + CW'(1);
            end
            idx_ff <= idx_ff + CW'(1);
         end
         U_REL_END: begin
            if (!found_ff) status_ff <= ST_NOT_FOUND;
         end
         U_RESP: begin
            rsp_ff.status      <= status_ff;
            rsp_ff.assigned_id <= assigned_ff;
            rsp_ff.running_id  <= run_valid_ff ? t_id : 16'd0;
            rsp_ff.finished_id <= fin_id_ff;
            rsp_ff.finish_time <= fin_time_ff;
            rsp_ff.system_time <= clk_ff;
            rsp_ff.all_done    <= done_ff;
         end
         default: ;
      endcase
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== rtl/process_scheduler_fcfs_prio_rr_unit.sv =====
// A command is taken in idle, then passes prepare, decode and response; the response state
// waits for room. A new command is taken only after the response is issued. Added steps:
// a ready sort of up to R passes (R = ready count > 1, not RR); an add scan over up to
// MAX_PROCS slots; for a tick, the RR slice check of a tick that does not finish and a head
// pop; a tail step for FCFS expiry; for unblock/resume, a walk over the queue and an end step.
// Sync active-high reset clears the control state.
module process_scheduler_fcfs_prio_rr_unit import psch_pkg::*; #(
   parameter int MAX_PROCS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);

   dp_cmd_type    cmd;
   dp_status_type stat;

   psch_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   psch_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

// ===== rtl/psch_checker.sv =====
// Port-level checks for the process scheduler, bound to the top level.
// Depends on psch_pkg.
module psch_checker import psch_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // No response right after reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Status code in defined range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 3'd7)
      else $error("undefined status code");

   // All done means nothing is running
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.all_done |-> rsp_data.running_id == 16'd0)
      else $error("all done with a running process");

   // A finish happens at the current system time
   a_fin_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finished_id != 16'd0 |->
         rsp_data.finish_time == rsp_data.system_time)
      else $error("finish time differs from system time");

endmodule

bind process_scheduler_fcfs_prio_rr_unit psch_checker u_psch_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== bench/tb.sv =====
// Self-checking bench for process_scheduler_fcfs_prio_rr_unit: a directed table,
// then random phases under several policy/slice settings, with a scheduler predictor.
// Depends on rtl/psch_pkg.sv and rtl/process_scheduler_fcfs_prio_rr_unit.sv.
`timescale 1ns / 1ps

module tb;
   import psch_pkg::*;

   localparam int NPROC = 16;
   localparam int Q_RDY = 0;
   localparam int Q_BLK = 1;
   localparam int Q_SUS = 2;
   localparam int W_FREE = 0;
   localparam int W_READY = 1;
   localparam int W_RUN = 2;
   localparam int W_BLOCKED = 3;
   localparam int W_SUSP = 4;
   localparam int PROF_MIX = 0;
   localparam int PROF_FILL = 1;
   localparam int N_PHASES = 8;
   localparam int PHASE_ITEMS = 225;

   logic       clock;
   logic       reset;
   logic       req_valid, req_ready;
   req_type    req_data;
   logic       rsp_valid, rsp_ready;
   rsp_type    rsp_data;
   logic       csr_valid, csr_ready;
   logic       csr_index;
   logic [7:0] csr_data;

   process_scheduler_fcfs_prio_rr_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   initial begin
      #30_000_000;
      $display("tb: failure");
      $finish;
   end

   // ---------------- scheduler predictor ----------------
   logic [1:0]  pol_mode;
   logic [7:0]  pol_slice;
   logic [15:0] p_id [NPROC];
   logic [3:0]  p_prio [NPROC];
   logic [31:0] p_arr [NPROC];
   logic [7:0]  p_rem [NPROC];
   logic [7:0]  p_used [NPROC];
   int          p_where [NPROC];
   int          qslot [3][NPROC];
   int          qlen [3];
   bit          run_v;
   int          run_s;
   logic [15:0] id_next;
   logic [31:0] cpu_now;
   bit          done_f;

   function automatic void sched_reset();
      pol_mode = MODE_FCFS;
      pol_slice = 8'd4;
      for (int i = 0; i < NPROC; i++) p_where[i] = W_FREE;
      for (int q = 0; q < 3; q++) qlen[q] = 0;
      run_v = 1'b0;
      run_s = 0;
      id_next = 16'd1;
      cpu_now = '0;
      done_f = 1'b0;
   endfunction

   function automatic void q_push(int q, int s, int w);
      if (qlen[q] < NPROC) begin
         qslot[q][qlen[q]] = s;
         qlen[q]++;
         p_where[s] = w;
      end
   endfunction

   function automatic int q_pop(int q);
      int s;
      s = qslot[q][0];
      for (int i = 1; i < qlen[q]; i++) qslot[q][i-1] = qslot[q][i];
      qlen[q]--;
      return s;
   endfunction

   function automatic bit goes_first(int x, int y);
      if (pol_mode == MODE_PRIO) return p_prio[x] > p_prio[y];
      return p_arr[x] < p_arr[y];
   endfunction

   // stable insertion sort of the ready queue by policy
   function automatic void order_ready();
      int v, j;
      if (pol_mode == MODE_RR) return;
      for (int i = 1; i < qlen[Q_RDY]; i++) begin
         v = qslot[Q_RDY][i];
         j = i;
         while (j > 0 && goes_first(v, qslot[Q_RDY][j-1])) begin
            qslot[Q_RDY][j] = qslot[Q_RDY][j-1];
            j--;
         end
         qslot[Q_RDY][j] = v;
      end
   endfunction

   function automatic void start_head();
      if (!run_v && qlen[Q_RDY] > 0) begin
         run_s = q_pop(Q_RDY);
         run_v = 1'b1;
         p_where[run_s] = W_RUN;
      end
   endfunction

   // every waiter with a matching id moves to the ready tail
   function automatic bit release_id(int q, logic [15:0] id);
      int k;
      bit hit;
      k = 0;
      hit = 1'b0;
      for (int i = 0; i < qlen[q]; i++) begin
         if (p_id[qslot[q][i]] == id) begin
            q_push(Q_RDY, qslot[q][i], W_READY);
            hit = 1'b1;
         end else begin
            qslot[q][k] = qslot[q][i];
            k++;
         end
      end
      qlen[q] = k;
      return hit;
   endfunction

   function automatic rsp_type sched_step(req_type r);
      rsp_type o;
      int      slot, q;
      int      sl;
      logic [7:0] serv;
      o = '0;
      o.status = ST_OK;
      order_ready();
      case (op_type'(r.opcode))
         OP_ADD: begin
            slot = NPROC;
            for (int i = NPROC - 1; i >= 0; i--) if (p_where[i] == W_FREE) slot = i;
            if (slot == NPROC) o.status = ST_TABLE_FULL;
            else begin
               serv = (r.service_time == 0) ? 8'd1 : r.service_time;
               p_id[slot] = id_next;
               p_prio[slot] = r.new_priority;
               p_arr[slot] = cpu_now + r.arrival_offset;
               p_rem[slot] = serv;
               p_used[slot] = '0;
               o.assigned_id = id_next;
               id_next++;
               if (id_next == 0) id_next = 16'd1;
               q_push(Q_RDY, slot, W_READY);
               done_f = 1'b0;
            end
         end
         OP_TICK: begin
            if (!run_v) begin
               if (qlen[Q_RDY] > 0) start_head();
               else if (qlen[Q_BLK] > 0 || qlen[Q_SUS] > 0) o.status = ST_WAITING;
               else begin
                  done_f = 1'b1;
                  o.status = ST_ALL_DONE;
               end
            end else begin
               sl = (pol_slice == 0) ? 1 : pol_slice;
               cpu_now++;
               p_used[run_s]++;
               p_rem[run_s]--;
               if (p_rem[run_s] == 0) begin
                  o.finished_id = p_id[run_s];
                  o.finish_time = cpu_now;
                  p_where[run_s] = W_FREE;
                  run_v = 1'b0;
               end else if (pol_mode == MODE_RR && p_used[run_s] != 0 &&
                            (p_used[run_s] % sl) == 0) begin
                  run_v = 1'b0;
                  q_push(Q_RDY, run_s, W_READY);
               end
               start_head();
            end
         end
         OP_EXPIRE: begin
            if (!run_v) o.status = ST_NO_RUNNING;
            else begin
               if ((pol_mode == MODE_FCFS || pol_mode == MODE_ALT) && qlen[Q_RDY] > 0)
                  p_arr[run_s] = p_arr[qslot[Q_RDY][qlen[Q_RDY]-1]] + 32'd1;
               run_v = 1'b0;
               q_push(Q_RDY, run_s, W_READY);
            end
         end
         OP_BLOCK, OP_SUSPEND: begin
            if (!run_v) o.status = ST_NO_RUNNING;
            else begin
               run_v = 1'b0;
               if (r.opcode == OP_BLOCK) q_push(Q_BLK, run_s, W_BLOCKED);
               else q_push(Q_SUS, run_s, W_SUSP);
            end
         end
         OP_UNBLOCK, OP_RESUME: begin
            q = (r.opcode == OP_UNBLOCK) ? Q_BLK : Q_SUS;
            if (qlen[q] == 0) o.status = ST_QUEUE_EMPTY;
            else if (!release_id(q, r.target_id)) o.status = ST_NOT_FOUND;
         end
         default: ;
      endcase
      o.running_id = run_v ? p_id[run_s] : 16'd0;
      o.system_time = cpu_now;
      o.all_done = done_f;
      return o;
   endfunction

   // ---------------- scoreboard ----------------
   rsp_type     sched_expected [$];
   logic [3:0]  typed_status [$];   // {typed, status}
   int          errors = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          status_seen [8];
   bit          hold_rsp = 1'b0;
   bit          calm = 1'b0;

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type    e;
      logic [3:0] t;
      if (!reset && req_valid && req_ready) begin
         sched_expected.push_back(sched_step(req_data));
         beats_in++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         status_seen[rsp_data.status]++;
         if (sched_expected.size() == 0) begin
            errors++;
            $display("%0t: response beat with nothing expected, status %0d",
                     $time, rsp_data.status);
         end else begin
            e = sched_expected.pop_front();
            t = typed_status.pop_front();
            if (t[3]) check_field("typed status", t[2:0], rsp_data.status);
            check_field("status", e.status, rsp_data.status);
            check_field("assigned_id", e.assigned_id, rsp_data.assigned_id);
            check_field("running_id", e.running_id, rsp_data.running_id);
            check_field("finished_id", e.finished_id, rsp_data.finished_id);
            check_field("finish_time", e.finish_time, rsp_data.finish_time);
            check_field("system_time", e.system_time, rsp_data.system_time);
            check_field("all_done", e.all_done, rsp_data.all_done);
         end
      end
   end

   // ---------------- response side ----------------
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = calm ? 0 : $urandom_range(0, 13);
         if (hold_rsp) begin
            n = 600;
            hold_rsp = 1'b0;
         end
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // ---------------- request side ----------------
   function automatic req_type mk(op_type op, logic [3:0] pr, logic [7:0] offs,
                                  logic [7:0] serv, logic [15:0] tgt);
      req_type r;
      r.opcode = op;
      r.new_priority = pr;
      r.arrival_offset = offs;
      r.service_time = serv;
      r.target_id = tgt;
      return r;
   endfunction

   function automatic logic [15:0] pick_target(int q);
      if (qlen[q] > 0 && $urandom_range(0, 3) != 0)
         return p_id[qslot[q][$urandom_range(0, qlen[q] - 1)]];
      if ($urandom_range(0, 1) == 1) return id_next - 16'($urandom_range(1, 20));
      return 16'($urandom);
   endfunction

   function automatic req_type random_cmd(int profile);
      int       w;
      op_type   op;
      logic [7:0] serv;
      w = $urandom_range(0, 99);
      if (profile == PROF_FILL) w = (w < 60) ? 0 : w;
      if (w < 25) op = OP_ADD;
      else if (w < 62) op = OP_TICK;
      else if (w < 70) op = OP_EXPIRE;
      else if (w < 77) op = OP_BLOCK;
      else if (w < 84) op = OP_UNBLOCK;
      else if (w < 90) op = OP_SUSPEND;
      else if (w < 97) op = OP_RESUME;
      else op = OP_NOP;
      serv = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 8));
      return mk(op, 4'($urandom), 8'($urandom), serv,
                pick_target(op == OP_RESUME ? Q_SUS : Q_BLK));
   endfunction

   task automatic send_cmd(req_type r, bit typed, logic [2:0] st);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_status.push_back({typed, st});
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      req_valid <= 1'b0;
      while (sched_expected.size() != 0) @(negedge clock);
      @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCHED_MODE) pol_mode = val[1:0];
      else pol_slice = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   typedef struct {
      req_type    cmd;
      bit         typed;
      logic [2:0] st;
   } dir_row_type;

   initial begin
      dir_row_type dir [$];
      logic [1:0]  ph_mode [N_PHASES];
      logic [7:0]  ph_slice [N_PHASES];
      int          waited;

      sched_reset();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = 1'b0;
      csr_data = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty-table corner cases, field extremes, each command
      dir.push_back('{mk(OP_TICK, 0, 0, 1, 0), 1, ST_ALL_DONE});
      dir.push_back('{mk(OP_EXPIRE, 0, 0, 1, 0), 1, ST_NO_RUNNING});
      dir.push_back('{mk(OP_BLOCK, 0, 0, 1, 0), 1, ST_NO_RUNNING});
      dir.push_back('{mk(OP_SUSPEND, 0, 0, 1, 0), 1, ST_NO_RUNNING});
      dir.push_back('{mk(OP_UNBLOCK, 0, 0, 1, 16'd5), 1, ST_QUEUE_EMPTY});
      dir.push_back('{mk(OP_RESUME, 0, 0, 1, 16'hFFFF), 1, ST_QUEUE_EMPTY});
      dir.push_back('{mk(OP_ADD, 4'hF, 8'hFF, 8'd0, 16'hFFFF), 1, ST_OK});
      dir.push_back('{mk(OP_ADD, 4'h0, 8'h00, 8'hFF, 0), 1, ST_OK});
      dir.push_back('{mk(OP_ADD, 4'h7, 8'h03, 8'd2, 0), 1, ST_OK});
      dir.push_back('{mk(OP_TICK, 0, 0, 1, 0), 1, ST_OK});
      dir.push_back('{mk(OP_EXPIRE, 0, 0, 1, 0), 1, ST_OK});
      dir.push_back('{mk(OP_TICK, 0, 0, 1, 0), 1, ST_OK});
      dir.push_back('{mk(OP_TICK, 0, 0, 1, 0), 0, ST_OK});
      dir.push_back('{mk(OP_BLOCK, 0, 0, 1, 0), 0, ST_OK});
      dir.push_back('{mk(OP_UNBLOCK, 0, 0, 1, 16'hFFFF), 1, ST_NOT_FOUND});
      dir.push_back('{mk(OP_TICK, 0, 0, 1, 0), 0, ST_OK});
      dir.push_back('{mk(OP_SUSPEND, 0, 0, 1, 0), 0, ST_OK});
      dir.push_back('{mk(OP_RESUME, 0, 0, 1, 16'd0), 1, ST_NOT_FOUND});
      dir.push_back('{mk(OP_NOP, 4'hF, 8'hFF, 8'hFF, 16'hFFFF), 1, ST_OK});
      dir.push_back('{mk(OP_UNBLOCK, 0, 0, 1, 16'd1), 0, ST_OK});
      dir.push_back('{mk(OP_UNBLOCK, 0, 0, 1, 16'd2), 0, ST_OK});
      dir.push_back('{mk(OP_RESUME, 0, 0, 1, 16'd3), 0, ST_OK});
      foreach (dir[i]) send_cmd(dir[i].cmd, dir[i].typed, dir[i].st);

      // random phases over policy and slice settings, extremes included
      ph_mode = '{MODE_PRIO, MODE_RR, MODE_RR, MODE_ALT, MODE_RR, MODE_FCFS, MODE_PRIO,
                  MODE_RR};
      ph_slice = '{8'd255, 8'd1, 8'd0, 8'd7, 8'd255, 8'd3, 8'd2, 8'd4};
      for (int p = 0; p < N_PHASES; p++) begin
         write_reg(CSR_SCHED_MODE, ph_mode[p]);
         write_reg(CSR_SLICE_LENGTH, ph_slice[p]);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            calm = (k >= 100 && k < 130);
            if (p == 2 && k == 60) hold_rsp = 1'b1;
            send_cmd(random_cmd((k % 75) < 20 ? PROF_FILL : PROF_MIX), 0, ST_OK);
         end
         calm = 1'b0;
      end
      req_valid <= 1'b0;

      waited = 0;
      while (sched_expected.size() != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (400) @(negedge clock);
      $display("tb: %0d commands sent, %0d responses checked over %0d policy settings",
               beats_in, beats_out, N_PHASES + 1);
      $display("tb: status ok/full/norun/empty/notfound/wait/done = %0d/%0d/%0d/%0d/%0d/%0d/%0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5], status_seen[6]);
      if (errors == 0 && sched_expected.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
